// ===== rtl/ntq_pkg.sv =====
// ----------------------------------------------------------------------------
// Note time quantizer package
// Shared constants, register codes and types of the note time quantizer.
// ----------------------------------------------------------------------------
package ntq_pkg;

  localparam int TIME_WIDTH_DEF = 31;
  localparam int EXP_W          = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;
  localparam int STATUS_W       = 8;
  localparam int OUT_W          = 32;

  // Working width: seven half triplet steps of a grid of 2^31 ticks need 33 bits.
  localparam int CALC_W         = 35;
  localparam int QUOT_MAX       = 7;
  localparam int RND_W          = 3;

  // Binary pattern of one third; shifting it right gives floor(2^n / 3).
  localparam logic [31:0] THIRD_PATTERN = 32'h5555_5555;
  localparam logic [EXP_W-1:0] EXP_TOP  = 5'd31;

  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

  typedef enum logic [1:0] {
    QM_START   = 2'd0,
    QM_END     = 2'd1,
    QM_HALFWAY = 2'd2
  } quant_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_EXP   = 2'd0,
    CFG_QUANT_MODE = 2'd1,
    CFG_TRIPLET    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [EXP_W-1:0] grid_exp;
    quant_mode_e      mode;
    logic             triplet;
  } cfg_t;

endpackage

// ===== rtl/ntq_if.sv =====
// ----------------------------------------------------------------------------
// Note time quantizer channels
// Valid/ready channels for incoming events and outgoing results.
// ----------------------------------------------------------------------------
interface ntq_evt_if #(
  parameter int TIME_WIDTH = ntq_pkg::TIME_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [TIME_WIDTH-1:0]         event_time;
  logic [ntq_pkg::STATUS_W-1:0]  status_byte;
  logic                          is_marked;

  modport source (output valid, event_time, status_byte, is_marked, input ready);
  modport sink   (input valid, event_time, status_byte, is_marked, output ready);
endinterface

interface ntq_res_if;
  logic                       valid;
  logic                       ready;
  logic [ntq_pkg::OUT_W-1:0]  new_time;
  logic                       was_moved;

  modport source (output valid, new_time, was_moved, input ready);
  modport sink   (input valid, new_time, was_moved, output ready);
endinterface

// ===== rtl/note_time_quantizer_unit.sv =====
// ----------------------------------------------------------------------------
// Note time quantizer unit
// Path: an event transfer passes the three working stages and then the output
//   register before its result is shown; a stall at the output holds it.
// Throughput: one event per cycle, set by the four-stage pipeline that
//   advances as a whole whenever the output register is empty or taken.
// Reset: asynchronous, active low; empties the pipeline and clears the
//   configuration registers to exponent zero, note-start mode, straight grid.
// ----------------------------------------------------------------------------
//
// Pipeline outline:
//   stage A  registers the event time and the filter decision (marked and
//            note-on, or note-off in end mode).
//   stage B  splits the time into bar and remainder, finds the quotient of
//            the remainder by half a triplet step with seven parallel
//            compares, and forms the straight-grid rounding.
//   stage C  multiplies the rounded quotient by the triplet step (shift and
//            add of at most three terms) and selects the quantized time.
//   output   applies the halfway move and saturates to 32 bits.
// The whole pipeline moves on one enable, so a stall at the output holds
// every stage and nothing is lost or repeated.
module note_time_quantizer_unit #(
  parameter int TIME_WIDTH = ntq_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ntq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ntq_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  ntq_evt_if.sink                          evt_i,
  ntq_res_if.source                        res_o
);

  localparam int CW = ntq_pkg::CALC_W;
  localparam int RW = ntq_pkg::RND_W;

  // Configuration registers.
  ntq_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_exp <= '0;
      cfg_q.mode     <= ntq_pkg::QM_START;
      cfg_q.triplet  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ntq_pkg::CFG_GRID_EXP:   cfg_q.grid_exp <= cfg_wdata_i[ntq_pkg::EXP_W-1:0];
        ntq_pkg::CFG_QUANT_MODE: cfg_q.mode     <= ntq_pkg::quant_mode_e'(cfg_wdata_i[1:0]);
        ntq_pkg::CFG_TRIPLET:    cfg_q.triplet  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Grid quantities that follow from the configuration alone. They are stable while
  // events are in flight if the user makes configuration changes only when idle; the block does not enforce it.
  logic [CW-1:0] grid_one;
  logic [CW-1:0] grid_mask;
  logic [CW-1:0] half_grid;
  logic [CW-1:0] bar_mask;
  logic [CW-1:0] trip_step;
  logic [CW-1:0] half_step;

  always_comb begin
    grid_one  = {{(CW-1){1'b0}}, 1'b1} << cfg_q.grid_exp;
    grid_mask = grid_one - {{(CW-1){1'b0}}, 1'b1};
    half_grid = grid_one >> 1;
    bar_mask  = (grid_one << 1) - {{(CW-1){1'b0}}, 1'b1};
    // floor(2^(e+1) / 3), taken from the repeating pattern of one third.
    trip_step = {{(CW-32){1'b0}}, ntq_pkg::THIRD_PATTERN} >> (ntq_pkg::EXP_TOP - cfg_q.grid_exp);
    half_step = trip_step >> 1;
  end

  // The pipeline advances whenever the output register is free or being taken.
  logic adv;
  logic res_valid_q;

  assign adv         = !res_valid_q || res_o.ready;
  assign evt_i.ready = adv;

  // Event filter.
  logic [3:0] kind;
  logic       hit_in;

  assign kind = evt_i.status_byte[7:4];

  always_comb begin
    case (cfg_q.mode)
      ntq_pkg::QM_END: hit_in = (kind == ntq_pkg::KIND_NOTE_OFF);
      default:         hit_in = (kind == ntq_pkg::KIND_NOTE_ON);
    endcase
    hit_in = hit_in && evt_i.is_marked;
  end

  // Stage A.
  logic                  a_valid_q;
  logic [TIME_WIDTH-1:0] a_time_q;
  logic                  a_hit_q;

  // Stage B logic: bar split, remainder quotient and straight-grid rounding.
  logic [CW-1:0]             a_time_x;
  logic [CW-1:0]             rest;
  logic [CW-1:0]             base;
  logic [ntq_pkg::QUOT_MAX-1:0] rest_ge;
  logic [RW-1:0]             quot;
  logic [RW-1:0]             rnd;
  logic [RW:0]               quot_inc;
  logic [CW-1:0]             nt_sum;
  logic [CW-1:0]             nt_z;

  always_comb begin
    a_time_x = {{(CW-TIME_WIDTH){1'b0}}, a_time_q};
    rest     = a_time_x & bar_mask;
    base     = a_time_x & ~bar_mask;
    // The remainder is below six half steps plus a little, so the quotient
    // never exceeds seven and a count of passed multiples gives it exactly.
    for (int k = 0; k < ntq_pkg::QUOT_MAX; k++) begin
      rest_ge[k] = (rest >= half_step * CW'(k + 1));
    end
    quot     = RW'($countones(rest_ge));
    quot_inc = {1'b0, quot} + {{RW{1'b0}}, 1'b1};
    rnd      = quot_inc[RW:1];
    // Round half up to the straight grid: add half a grid and clear the fraction.
    nt_sum   = a_time_x + half_grid;
    nt_z     = nt_sum & ~grid_mask;
  end

  // Stage B.
  logic                  b_valid_q;
  logic [TIME_WIDTH-1:0] b_time_q;
  logic                  b_hit_q;
  logic [TIME_WIDTH-1:0] b_base_q;
  logic [RW-1:0]         b_rnd_q;
  logic [CW-1:0]         b_nt_q;

  // Stage C logic: triplet product and selection of the quantized time.
  logic [CW-1:0] prod;
  logic [CW-1:0] b_time_x;
  logic [CW-1:0] trip_z;
  logic [CW-1:0] z_c;

  always_comb begin
    prod = (b_rnd_q[2] ? (trip_step << 2) : '0)
         + (b_rnd_q[1] ? (trip_step << 1) : '0)
         + (b_rnd_q[0] ? trip_step : '0);
    b_time_x = {{(CW-TIME_WIDTH){1'b0}}, b_time_q};
    trip_z   = {{(CW-TIME_WIDTH){1'b0}}, b_base_q} + prod;
    if (!b_hit_q || cfg_q.grid_exp == '0) begin
      z_c = b_time_x;
    end else if (cfg_q.triplet) begin
      // A triplet step of one has no half step; such times pass unchanged.
      z_c = (half_step == '0) ? b_time_x : trip_z;
    end else begin
      z_c = b_nt_q;
    end
  end

  // Stage C.
  logic                  c_valid_q;
  logic [TIME_WIDTH-1:0] c_time_q;
  logic                  c_hit_q;
  logic [CW-1:0]         c_z_q;

  // Output stage logic: halfway move and saturation.
  logic [CW-1:0]          avg_sum;
  logic [CW-1:0]          z_d;
  logic [ntq_pkg::OUT_W-1:0] res_time_d;

  always_comb begin
    avg_sum = c_z_q + {{(CW-TIME_WIDTH){1'b0}}, c_time_q};
    if (c_hit_q && cfg_q.mode == ntq_pkg::QM_HALFWAY) begin
      z_d = avg_sum >> 1;
    end else begin
      z_d = c_z_q;
    end
    if (z_d[CW-1:ntq_pkg::OUT_W] != '0) begin
      res_time_d = '1;
    end else begin
      res_time_d = z_d[ntq_pkg::OUT_W-1:0];
    end
  end

  // Output register.
  logic [ntq_pkg::OUT_W-1:0] res_time_q;
  logic                      res_moved_q;

  // Valid bits travel with the data and are the only pipeline state reset clears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= evt_i.valid;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      res_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_time_q    <= evt_i.event_time;
      a_hit_q     <= hit_in;
      b_time_q    <= a_time_q;
      b_hit_q     <= a_hit_q;
      b_base_q    <= base[TIME_WIDTH-1:0];
      b_rnd_q     <= rnd;
      b_nt_q      <= nt_z;
      c_time_q    <= b_time_q;
      c_hit_q     <= b_hit_q;
      c_z_q       <= z_c;
      res_time_q  <= res_time_d;
      res_moved_q <= c_hit_q;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.new_time  = res_time_q;
  assign res_o.was_moved = res_moved_q;

endmodule

// ===== rtl/ntq_checker.sv =====
// ----------------------------------------------------------------------------
// Note time quantizer checker
// Port-level checks on flow and latency of the note time quantizer unit.
// ----------------------------------------------------------------------------
module ntq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [ntq_pkg::OUT_W-1:0] new_time_i,
  input logic                      was_moved_i
);

  // A result that is held back stays and keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(new_time_i) && $stable(was_moved_i))
    else $error("result changed while stalled");

  // With the output register empty the unit must take a new event.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked while output register empty");

  // An event that meets no stall on its way through the pipeline reaches the output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 in_ready_i ##1 in_ready_i ##1 in_ready_i |=> out_valid_i)
    else $error("result missing after pipeline latency");

endmodule

bind note_time_quantizer_unit ntq_checker u_ntq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (evt_i.valid),
  .in_ready_i  (evt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .new_time_i  (res_o.new_time),
  .was_moved_i (res_o.was_moved)
);
